// File: rtl/hufd_pkg.sv
`timescale 1ns / 1ps

package hufd_pkg;

	// Default sizing of the tree store and of the symbol counter.
	localparam int TREE_NODES_DEF  = 255;
	localparam int LENGTH_BITS_DEF = 24;

	// Field widths of the input and result beats.
	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 8;
	localparam int CHILD_W  = 9;
	localparam int LENGTH_W = 24;
	localparam int BYTE_W   = 8;
	localparam int SYMBOL_W = 8;
	localparam int ENTRY_W  = 2 * CHILD_W;
	localparam int BIT_IDX_W = $clog2(BYTE_W);

	// Action codes carried in the slave tuser.
	localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DECODE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic step;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic decode_go;
		logic leaf;
		logic chunk_done;
		logic last_bit;
		logic pend_valid;
		logic pend_end;
		logic out_free;
		logic chunk_active;
		logic left_zero;
	} stat_t;

endpackage

// File: rtl/hufd_ctrl.sv
`timescale 1ns / 1ps

module hufd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  hufd_pkg::stat_t stat,
	output hufd_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       step_ok;

	// A leaf may only displace the held symbol if the output slot is free.
	assign step_ok  = (state_q == ST_WALK) &&
		!(stat.leaf && stat.pend_valid && !stat.out_free);
	assign s_tready = (state_q == ST_IDLE);

	assign cmd.take  = s_tvalid && s_tready;
	assign cmd.step  = step_ok;
	assign cmd.flush = (state_q == ST_FLUSH);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && stat.decode_go) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (step_ok && (stat.last_bit || stat.chunk_done)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid || stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/hufd_datapath.sv
`timescale 1ns / 1ps

module hufd_datapath #(
	parameter int TREE_NODES  = hufd_pkg::TREE_NODES_DEF,
	parameter int LENGTH_BITS = hufd_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hufd_pkg::ACTION_W-1:0] action,
	input  logic [hufd_pkg::INDEX_W-1:0]  node_index,
	input  logic [hufd_pkg::CHILD_W-1:0]  child_zero,
	input  logic [hufd_pkg::CHILD_W-1:0]  child_one,
	input  logic [hufd_pkg::LENGTH_W-1:0] chunk_length,
	input  logic [hufd_pkg::BYTE_W-1:0]   data_byte,
	input  hufd_pkg::cmd_t                cmd,
	output hufd_pkg::stat_t               stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hufd_pkg::SYMBOL_W-1:0] symbol,
	output logic                          chunk_end,
	output logic                          last_of_run
);

	localparam int NODE_W = $clog2(TREE_NODES);
	localparam logic [NODE_W-1:0] HEAD_NODE = NODE_W'(TREE_NODES - 1);
	localparam logic [hufd_pkg::INDEX_W-1:0] NODE_LIMIT = hufd_pkg::INDEX_W'(TREE_NODES);
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam logic [hufd_pkg::BIT_IDX_W-1:0] TOP_BIT =
		hufd_pkg::BIT_IDX_W'(hufd_pkg::BYTE_W - 1);

	logic [hufd_pkg::ENTRY_W-1:0]   tree_mem [TREE_NODES];
	logic [hufd_pkg::ENTRY_W-1:0]   rd_data_q;
	logic [NODE_W-1:0]              rd_addr;
	logic [NODE_W-1:0]              walk_node_q;
	logic [NODE_W-1:0]              next_node;
	logic [LENGTH_BITS-1:0]         symbols_left_q;
	logic [LENGTH_BITS-1:0]         start_len;
	logic                           active_q;
	logic [hufd_pkg::BYTE_W-1:0]    byte_q;
	logic [hufd_pkg::BIT_IDX_W-1:0] bit_idx_q;
	logic                           pend_valid_q;
	logic [hufd_pkg::SYMBOL_W-1:0]  pend_sym_q;
	logic                           pend_end_q;
	logic                           out_valid_q;
	logic [hufd_pkg::SYMBOL_W-1:0]  out_sym_q;
	logic                           out_end_q;
	logic                           out_last_q;
	logic [hufd_pkg::CHILD_W-1:0]   child;
	logic [hufd_pkg::INDEX_W-1:0]   ptr;
	logic                           leaf;
	logic                           chunk_done;
	logic                           out_free;
	logic                           push;
	logic                           do_load;
	logic                           do_start;
	logic                           final_push;

	// Branch selection on the current bit of the byte.
	assign child      = byte_q[bit_idx_q] ? rd_data_q[hufd_pkg::ENTRY_W-1:hufd_pkg::CHILD_W]
	                                      : rd_data_q[hufd_pkg::CHILD_W-1:0];
	assign leaf       = !child[hufd_pkg::CHILD_W-1];
	assign ptr        = child[hufd_pkg::INDEX_W-1:0];
	assign chunk_done = leaf && (symbols_left_q == LEN_ONE);

	// A pointer past the tree drops the partial code and restarts at the head.
	always_comb begin
		next_node = HEAD_NODE;
		if (!leaf && (ptr < NODE_LIMIT)) begin
			next_node = ptr[NODE_W-1:0];
		end
	end

	// The read address runs one node ahead while the walk advances.
	assign rd_addr = cmd.step ? next_node : walk_node_q;

	assign start_len  = LENGTH_BITS'(chunk_length);
	assign do_load    = cmd.take && (action == hufd_pkg::ACT_LOAD) && (node_index < NODE_LIMIT);
	assign do_start   = cmd.take && (action == hufd_pkg::ACT_START) && (start_len != '0);
	assign out_free   = !out_valid_q || m_tready;
	assign final_push = cmd.flush && pend_valid_q && out_free;
	assign push       = (cmd.step && leaf && pend_valid_q) || final_push;

	// Tree store: one write port for loads, one registered read port for the walk.
	always_ff @(posedge clk) begin
		if (do_load) begin
			tree_mem[node_index[NODE_W-1:0]] <= {child_one, child_zero};
		end
		rd_data_q <= tree_mem[rd_addr];
	end

	// Walk, chunk and held-symbol control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_node_q    <= HEAD_NODE;
			symbols_left_q <= '0;
			active_q       <= 1'b0;
			bit_idx_q      <= '0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (do_start) begin
				symbols_left_q <= start_len;
				active_q       <= 1'b1;
				walk_node_q    <= HEAD_NODE;
			end
			if (cmd.take) begin
				bit_idx_q <= '0;
			end
			if (cmd.step) begin
				walk_node_q <= next_node;
				bit_idx_q   <= bit_idx_q + 1'b1;
				if (leaf) begin
					symbols_left_q <= symbols_left_q - LEN_ONE;
					pend_valid_q   <= 1'b1;
					if (chunk_done) begin
						active_q <= 1'b0;
					end
				end
			end
			if (final_push) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: byte under decode, held symbol and output beat.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= data_byte;
		end
		if (cmd.step && leaf) begin
			pend_sym_q <= child[hufd_pkg::SYMBOL_W-1:0];
			pend_end_q <= chunk_done;
		end
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_end_q  <= pend_end_q;
			out_last_q <= cmd.flush;
		end
	end

	assign m_tvalid    = out_valid_q;
	assign symbol      = out_sym_q;
	assign chunk_end   = out_end_q;
	assign last_of_run = out_last_q;

	assign stat.decode_go    = (action == hufd_pkg::ACT_DECODE) && active_q;
	assign stat.leaf         = leaf;
	assign stat.chunk_done   = chunk_done;
	assign stat.last_bit     = (bit_idx_q == TOP_BIT);
	assign stat.pend_valid   = pend_valid_q;
	assign stat.pend_end     = pend_end_q;
	assign stat.out_free     = out_free;
	assign stat.chunk_active = active_q;
	assign stat.left_zero    = (symbols_left_q == '0);

endmodule

// File: rtl/huffman_tree_decoder.sv
`timescale 1ns / 1ps

// Huffman tree decoder. Load beats write one tree node each, a start beat opens
// a chunk of a given symbol count, and each decode beat walks the tree over the
// eight bits of one compressed byte, least significant bit first, from the node
// where the walk last stopped (the head node after a start). Load and start
// beats, and a decode beat that arrives with no open chunk, are only accepted.
// Any other decode beat is accepted, fetches the current node from the tree
// store, walks one bit per step, and releases the last symbol, if any, with tlast set.
// A byte that closes its chunk stops walking at that bit. Each step needs the
// registered read of the node chosen by the step before. A symbol leaves only
// when the next one is found or the byte ends, so a stalled master side holds
// the walk. Decoding before the nodes it reaches have been loaded gives
// undefined symbols.
module huffman_tree_decoder #(
	parameter int TREE_NODES  = hufd_pkg::TREE_NODES_DEF,
	parameter int LENGTH_BITS = hufd_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// node_index[7:0], child_zero[16:8], child_one[25:17], chunk_length[49:26],
	// data_byte[57:50], zero fill above
	input  logic [63:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// symbol[7:0]
	output logic [7:0]  m_tdata,
	// last_of_run
	output logic        m_tlast,
	// chunk_end[0]
	output logic        m_tuser
);

	hufd_pkg::cmd_t  cmd;
	hufd_pkg::stat_t stat;

	hufd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hufd_datapath #(
		.TREE_NODES  (TREE_NODES),
		.LENGTH_BITS (LENGTH_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (s_tuser),
		.node_index   (s_tdata[7:0]),
		.child_zero   (s_tdata[16:8]),
		.child_one    (s_tdata[25:17]),
		.chunk_length (s_tdata[49:26]),
		.data_byte    (s_tdata[57:50]),
		.cmd          (cmd),
		.stat         (stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.symbol       (m_tdata),
		.chunk_end    (m_tuser),
		.last_of_run  (m_tlast)
	);

	// No symbol may still be held back while a new beat can be taken.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.pend_valid)
		else $error("held symbol left over while accepting");

	// A chunk is open exactly while symbols are still owed.
	a_count_active: assert property (@(posedge clk) disable iff (!arst_n)
		stat.chunk_active != stat.left_zero)
		else $error("chunk flag and symbol count disagree");

	// The symbol that closes a chunk is held only after the chunk has closed.
	a_end_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.pend_valid && stat.pend_end) |-> !stat.chunk_active)
		else $error("closing symbol held with chunk still open");

	// The symbol that ends a chunk is always the last of its byte.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("chunk end without last of run");

endmodule

// File: sim/huffman_tree_decoder_tb.sv
`timescale 1ns / 1ps

module huffman_tree_decoder_tb;
	import hufd_pkg::*;

	localparam int NODE_COUNT = TREE_NODES_DEF;
	localparam logic [INDEX_W-1:0] HEAD_IDX = INDEX_W'(NODE_COUNT - 1);
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int LONG_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int END_SLACK = 24;
	localparam int REPORT_MAX = 10;

	// One input beat, fields at the widths of the block.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [INDEX_W-1:0]  node_index;
		logic [CHILD_W-1:0]  child_zero;
		logic [CHILD_W-1:0]  child_one;
		logic [LENGTH_W-1:0] chunk_length;
		logic [BYTE_W-1:0]   data_byte;
	} code_beat_t;

	// One decoded symbol as it should leave the block.
	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                chunk_end;
		logic                last_of_run;
	} symbol_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	// Software copy of the decoder state.
	logic [ENTRY_W-1:0]  node_store [NODE_COUNT];
	logic [INDEX_W-1:0]  walk_at;
	logic [LENGTH_W-1:0] owed;
	bit                  chunk_open;

	symbol_out_t        symbols_due [$];
	logic [INDEX_W-1:0] tree_members [$];

	int mismatches;
	int items_sent;
	int symbols_checked;
	int chunk_ends_seen;
	int burst_left;
	int holds_asked;
	int holds_done;
	int idle_cycles;
	symbol_out_t got_symbol;
	symbol_out_t want_symbol;

	huffman_tree_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one accepted beat to the model and queues the symbols it yields.
	task automatic advance_model(input code_beat_t b);
		symbol_out_t run [$];
		symbol_out_t s;
		logic [ENTRY_W-1:0] entry;
		logic [CHILD_W-1:0] branch;
		case (b.action)
			ACT_LOAD: begin
				if (b.node_index < NODE_COUNT)
					node_store[b.node_index] = {b.child_one, b.child_zero};
			end
			ACT_START: begin
				if (b.chunk_length != '0) begin
					owed = b.chunk_length;
					chunk_open = 1'b1;
					walk_at = HEAD_IDX;
				end
			end
			ACT_DECODE: begin
				// Walk the eight bits, low bit first, until the byte or the chunk ends.
				for (int i = 0; i < BYTE_W && chunk_open; i++) begin
					entry = node_store[walk_at];
					branch = b.data_byte[i] ? entry[ENTRY_W-1:CHILD_W] : entry[CHILD_W-1:0];
					if (!branch[CHILD_W-1]) begin
						owed = owed - 1'b1;
						s.symbol = branch[SYMBOL_W-1:0];
						s.chunk_end = (owed == '0);
						s.last_of_run = 1'b0;
						run.push_back(s);
						walk_at = HEAD_IDX;
						if (owed == '0)
							chunk_open = 1'b0;
					end else if (branch[INDEX_W-1:0] < NODE_COUNT) begin
						walk_at = branch[INDEX_W-1:0];
					end else begin
						walk_at = HEAD_IDX;
					end
				end
				if (run.size() > 0)
					run[run.size()-1].last_of_run = 1'b1;
				foreach (run[i])
					symbols_due.push_back(run[i]);
			end
			default: ;
		endcase
	endtask

	// Sends one beat in bursts with random gaps and updates the model on acceptance.
	task automatic send_item(input code_beat_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= b.action;
		s_tdata <= {6'd0, b.data_byte, b.chunk_length, b.child_one, b.child_zero, b.node_index};
		do @(posedge clk); while (!s_tready);
		advance_model(b);
		items_sent++;
	endtask

	// Stops offering beats until every queued symbol has arrived.
	task automatic drain_results(input int slack);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (symbols_due.size() != 0)
			@(posedge clk);
		repeat (slack) @(posedge clk);
	endtask

	// Unused fields carry random junk that the block must ignore.
	function automatic code_beat_t random_beat();
		code_beat_t b;
		b.action = ACT_UNUSED;
		b.node_index = INDEX_W'($urandom_range(0, 255));
		b.child_zero = CHILD_W'($urandom_range(0, 510));
		b.child_one = CHILD_W'($urandom_range(0, 510));
		b.chunk_length = LENGTH_W'($urandom);
		b.data_byte = BYTE_W'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic code_beat_t load_beat(input logic [INDEX_W-1:0] idx,
			input logic [CHILD_W-1:0] zero, input logic [CHILD_W-1:0] one);
		code_beat_t b;
		b = random_beat();
		b.action = ACT_LOAD;
		b.node_index = idx;
		b.child_zero = zero;
		b.child_one = one;
		return b;
	endfunction

	function automatic code_beat_t start_beat(input logic [LENGTH_W-1:0] len);
		code_beat_t b;
		b = random_beat();
		b.action = ACT_START;
		b.chunk_length = len;
		return b;
	endfunction

	function automatic code_beat_t byte_beat(input logic [BYTE_W-1:0] value);
		code_beat_t b;
		b = random_beat();
		b.action = ACT_DECODE;
		b.data_byte = value;
		return b;
	endfunction

	// A child is a leaf symbol or a pointer that stays inside the loaded tree.
	function automatic logic [CHILD_W-1:0] pick_child();
		logic [CHILD_W-1:0] c;
		if ($urandom_range(0, 9) < 6)
			c = CHILD_W'($urandom_range(0, 255));
		else
			c = {1'b1, tree_members[$urandom_range(0, tree_members.size() - 1)]};
		return c;
	endfunction

	// Mostly short chunks, now and then a zero or a very long length.
	function automatic logic [LENGTH_W-1:0] pick_length();
		int r;
		logic [LENGTH_W-1:0] len;
		r = $urandom_range(0, 9);
		if (r == 0)
			len = '0;
		else if (r == 1)
			len = LENGTH_W'($urandom);
		else
			len = LENGTH_W'($urandom_range(1, 24));
		return len;
	endfunction

	// Loads a fresh small tree; the head node is always part of it.
	task automatic load_random_tree(input int node_total);
		logic [INDEX_W-1:0] idx;
		tree_members.delete();
		tree_members.push_back(HEAD_IDX);
		while (tree_members.size() < node_total) begin
			idx = INDEX_W'($urandom_range(0, NODE_COUNT - 2));
			tree_members.push_back(idx);
		end
		foreach (tree_members[i])
			send_item(load_beat(tree_members[i], pick_child(), pick_child()));
	endtask

	task automatic run_chunk(input logic [LENGTH_W-1:0] len, input int max_bytes);
		send_item(start_beat(len));
		for (int k = 0; k < max_bytes && chunk_open; k++)
			send_item(byte_beat(BYTE_W'($urandom_range(0, 255))));
	endtask

	// Hand-built tree: head takes bit 0 to node 1 and bit 1 to symbol 255; node 1
	// goes to node 0 or back to the head; node 0 holds symbols 0 and 0xAA.
	task automatic test_directed_cases();
		code_beat_t b;
		send_item(byte_beat(8'h5A));
		b = random_beat();
		b.action = ACT_UNUSED;
		send_item(b);
		send_item(load_beat(8'd255, 9'd510, 9'd510));
		send_item(load_beat(HEAD_IDX, 9'd257, 9'd255));
		send_item(load_beat(8'd1, 9'd256, 9'd510));
		send_item(load_beat(8'd0, 9'd0, 9'h0AA));
		send_item(start_beat(24'd0));
		send_item(byte_beat(8'hFF));
		send_item(start_beat(24'd3));
		send_item(byte_beat(8'hFF));
		send_item(byte_beat(8'h00));
		send_item(start_beat(24'hFFFFFF));
		send_item(byte_beat(8'h00));
		send_item(byte_beat(8'hA5));
		// A restart mid-chunk, then a byte that only loops between head and node 1.
		send_item(start_beat(24'd5));
		send_item(byte_beat(8'hAA));
		send_item(byte_beat(8'hFE));
		send_item(start_beat(24'd1));
		send_item(byte_beat(8'h80));
		send_item(byte_beat(8'h00));
		tree_members.delete();
		tree_members.push_back(HEAD_IDX);
		tree_members.push_back(8'd1);
		tree_members.push_back(8'd0);
	endtask

	task automatic test_random_trees();
		repeat (6) begin
			load_random_tree($urandom_range(2, 7));
			repeat (3)
				run_chunk(pick_length(), 8);
		end
	endtask

	// Receiver holds off while bytes keep coming, then the sender waits for all.
	task automatic test_output_backpressure();
		send_item(start_beat(24'd200));
		holds_asked++;
		repeat (12)
			send_item(byte_beat(BYTE_W'($urandom_range(0, 255))));
		drain_results(0);
	endtask

	// Mixed actions: reloads mid-chunk, restarts, refused starts, idle bytes.
	task automatic test_mixed_noise();
		code_beat_t b;
		int pick;
		repeat (60) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				b = random_beat();
				b.action = ACT_UNUSED;
				send_item(b);
			end else if (pick < 18) begin
				if ($urandom_range(0, 3) == 0)
					send_item(load_beat(8'd255, pick_child(), pick_child()));
				else
					send_item(load_beat(tree_members[$urandom_range(0, tree_members.size() - 1)],
						pick_child(), pick_child()));
			end else if (pick < 30 || (!chunk_open && pick < 60)) begin
				send_item(start_beat(pick_length()));
			end else begin
				send_item(byte_beat(BYTE_W'($urandom_range(0, 255))));
			end
		end
	endtask

	// Receiver: changing stall patterns, plus long holds on request.
	initial begin : receiver
		int pattern;
		int pattern_left;
		int tick;
		pattern = 0;
		pattern_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (holds_asked != holds_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else begin
				if (pattern_left == 0) begin
					pattern = $urandom_range(0, 3);
					pattern_left = $urandom_range(10, 80);
				end
				pattern_left--;
				case (pattern)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (tick % 4) != 0;
					default: m_tready <= ($urandom_range(0, 9) < 2);
				endcase
			end
		end
	end

	// Compare each result beat with the oldest expected symbol.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_symbol = {m_tdata, m_tuser, m_tlast};
			if (symbols_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected symbol %0d end %0d last %0d", m_tdata, m_tuser, m_tlast);
			end else begin
				want_symbol = symbols_due.pop_front();
				symbols_checked++;
				if (want_symbol.chunk_end)
					chunk_ends_seen++;
				if (got_symbol !== want_symbol) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: symbol %0d exp %0d, end %0d exp %0d, last %0d exp %0d",
							got_symbol.symbol, want_symbol.symbol,
							got_symbol.chunk_end, want_symbol.chunk_end,
							got_symbol.last_of_run, want_symbol.last_of_run);
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles without a beat", idle_cycles);
			$display("huffman_tree_decoder_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		arst_n <= 1'b0;
		idle_cycles = 0;
		mismatches = 0;
		items_sent = 0;
		symbols_checked = 0;
		chunk_ends_seen = 0;
		burst_left = 0;
		holds_asked = 0;
		holds_done = 0;
		walk_at = HEAD_IDX;
		owed = '0;
		chunk_open = 1'b0;
		foreach (node_store[i])
			node_store[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_trees();
		test_output_backpressure();
		test_mixed_noise();
		drain_results(END_SLACK);

		$display("Sent %0d beats (loads, starts, bytes, unknown actions) over random trees.",
			items_sent);
		$display("Checked %0d symbols, %0d of them closing a chunk; mismatches: %0d.",
			symbols_checked, chunk_ends_seen, mismatches);
		if (mismatches == 0 && symbols_due.size() == 0)
			$display("huffman_tree_decoder_tb passed");
		else
			$display("huffman_tree_decoder_tb failed");
		$finish;
	end

endmodule
